### rtl/core/envgen_pkg.sv
// ----------------------------------------------------------------------------
// envgen_pkg
// Shared types and codes for the envelope generator: phases, opcodes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package envgen_pkg;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY1  = 3'd1,
        PH_DECAY2  = 3'd2,
        PH_RELEASE = 3'd3,
        PH_SILENT  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    localparam int unsigned REG_IDX_BITS = 3;
    localparam int unsigned ADDR_BITS    = 5;

    localparam logic [REG_IDX_BITS-1:0] REG_CURVE_SHAPE       = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_GAIN       = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FIRST_DECAY_GAIN  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SECOND_DECAY_GAIN = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_GAIN      = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_PEAK_LEVEL        = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_BREAK_LEVEL       = 3'd6;

    localparam logic [23:0] PEAK_LEVEL_RESET  = 24'd8388608;
    localparam logic [23:0] BREAK_LEVEL_RESET = 24'd4194304;

endpackage

### rtl/core/envelope_generator.sv
// ----------------------------------------------------------------------------
// envelope_generator
// Five-phase amplitude envelope applied to an audio sample stream, with
// linear or exponential level steps and an APB-style register port.
// ----------------------------------------------------------------------------
// One transaction is taken per clock while in_stall is low. Each transaction
// goes into an input register and is resolved by one pass of logic that
// scales the sample by the current level and steps the level (one adder or
// one 24x31 multiplier, then saturation and the phase compares); the updated
// level and phase are back in their registers in time for the following
// transaction, so a result moves from the input register to the result
// register, at one result per cycle while the output is not stalled.
// Note-on and note-off update the phase only; they and unused opcodes give
// no result. Stall on the output holds the result register and lets one
// further transaction wait in the input register.
module envelope_generator #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned LEVEL_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic [2:0]                          phase_now,
    output logic                                voice_done,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [envgen_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import envgen_pkg::*;

    localparam int unsigned PROD_W = SAMPLE_BITS + LEVEL_BITS + 1;
    localparam int unsigned SUM_W  = ((LEVEL_BITS >= 32) ? LEVEL_BITS : 32) + 2;
    localparam int unsigned EXP_W  = LEVEL_BITS + 31;
    localparam int unsigned FRAC_L = LEVEL_BITS - 1;
    localparam int unsigned FRAC_M = 29;

    // configuration registers
    logic                    curve_shape_reg;
    logic signed [31:0]      attack_gain_reg;
    logic signed [31:0]      first_decay_gain_reg;
    logic signed [31:0]      second_decay_gain_reg;
    logic signed [31:0]      release_gain_reg;
    logic [LEVEL_BITS-1:0]   peak_level_reg;
    logic [LEVEL_BITS-1:0]   break_level_reg;

    // input register
    logic                          s1_valid_reg;
    logic [1:0]                    s1_opcode_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;

    // envelope state
    logic [LEVEL_BITS-1:0]   level_reg;
    logic [LEVEL_BITS-1:0]   level_next;
    phase_t                  phase_reg;
    phase_t                  phase_next;

    // result register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    phase_t                        phase_now_reg;
    logic                          voice_done_reg;

    logic                          advance;
    logic                          in_accept;
    logic                          cfg_write;
    logic [REG_IDX_BITS-1:0]       reg_idx;
    logic                          produce;
    logic                          done_next;

    logic signed [31:0]            gain_sel;
    logic signed [PROD_W-1:0]      scale_prod;
    logic signed [PROD_W-1:0]      scale_shift;
    logic signed [SAMPLE_BITS-1:0] scaled;
    logic signed [SUM_W-1:0]       lin_sum;
    logic [EXP_W-1:0]              exp_prod;
    logic [LEVEL_BITS-1:0]         lin_level;
    logic [LEVEL_BITS-1:0]         exp_level;
    logic [LEVEL_BITS-1:0]         stepped;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ADDR_BITS-1:2];
    assign pready    = 1'b1;

    // register read back
    always_comb
    begin
        unique case (reg_idx)
            REG_CURVE_SHAPE:       prdata = {31'd0, curve_shape_reg};
            REG_ATTACK_GAIN:       prdata = attack_gain_reg;
            REG_FIRST_DECAY_GAIN:  prdata = first_decay_gain_reg;
            REG_SECOND_DECAY_GAIN: prdata = second_decay_gain_reg;
            REG_RELEASE_GAIN:      prdata = release_gain_reg;
            REG_PEAK_LEVEL:        prdata = 32'(peak_level_reg);
            REG_BREAK_LEVEL:       prdata = 32'(break_level_reg);
            default:               prdata = 32'd0;
        endcase
    end

    // gain of the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_ATTACK:  gain_sel = attack_gain_reg;
            PH_DECAY1:  gain_sel = first_decay_gain_reg;
            PH_DECAY2:  gain_sel = second_decay_gain_reg;
            PH_RELEASE: gain_sel = release_gain_reg;
            default:    gain_sel = 32'sd0;
        endcase
    end

    // sample scaling by the old level, floor then saturate
    assign scale_prod  = PROD_W'(s1_sample_reg) * $signed(PROD_W'(level_reg));
    assign scale_shift = scale_prod >>> FRAC_L;

    always_comb
    begin
        if ((&scale_shift[PROD_W-1:SAMPLE_BITS-1]) || !(|scale_shift[PROD_W-1:SAMPLE_BITS-1]))
        begin
            scaled = scale_shift[SAMPLE_BITS-1:0];
        end
        else if (scale_shift[PROD_W-1])
        begin
            scaled = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            scaled = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // linear step
    assign lin_sum = $signed(SUM_W'(level_reg)) + SUM_W'(gain_sel);

    always_comb
    begin
        if (lin_sum[SUM_W-1])
        begin
            lin_level = '0;
        end
        else if (|lin_sum[SUM_W-2:LEVEL_BITS])
        begin
            lin_level = '1;
        end
        else
        begin
            lin_level = lin_sum[LEVEL_BITS-1:0];
        end
    end

    // exponential step, Q2.29 multiplier
    assign exp_prod = EXP_W'(level_reg) * EXP_W'(gain_sel[30:0]);

    always_comb
    begin
        if (gain_sel[31] || !(|gain_sel))
        begin
            exp_level = '0;
        end
        else if (|exp_prod[EXP_W-1:LEVEL_BITS+FRAC_M])
        begin
            exp_level = '1;
        end
        else
        begin
            exp_level = exp_prod[LEVEL_BITS+FRAC_M-1:FRAC_M];
        end
    end

    assign stepped = curve_shape_reg ? exp_level : lin_level;

    // phase and level update
    always_comb
    begin
        phase_next = phase_reg;
        level_next = level_reg;
        produce    = 1'b0;
        done_next  = 1'b0;
        if (s1_valid_reg && advance)
        begin
            case (s1_opcode_reg)
                OP_NOTE_ON:  phase_next = PH_ATTACK;
                OP_NOTE_OFF: phase_next = PH_RELEASE;
                OP_SAMPLE:
                begin
                    produce    = 1'b1;
                    level_next = stepped;
                    unique case (phase_reg)
                        PH_ATTACK:
                        begin
                            if (stepped >= peak_level_reg)
                            begin
                                phase_next = PH_DECAY1;
                            end
                        end
                        PH_DECAY1:
                        begin
                            if (stepped <= break_level_reg)
                            begin
                                phase_next = PH_DECAY2;
                            end
                        end
                        PH_DECAY2, PH_RELEASE:
                        begin
                            if (stepped == '0)
                            begin
                                phase_next = PH_SILENT;
                                done_next  = 1'b1;
                            end
                        end
                        default: phase_next = PH_SILENT;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_shape_reg       <= 1'b0;
            attack_gain_reg       <= '0;
            first_decay_gain_reg  <= '0;
            second_decay_gain_reg <= '0;
            release_gain_reg      <= '0;
            peak_level_reg        <= LEVEL_BITS'(PEAK_LEVEL_RESET);
            break_level_reg       <= LEVEL_BITS'(BREAK_LEVEL_RESET);
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            level_reg             <= '0;
            phase_reg             <= PH_SILENT;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx)
                    REG_CURVE_SHAPE:       curve_shape_reg       <= pwdata[0];
                    REG_ATTACK_GAIN:       attack_gain_reg       <= pwdata;
                    REG_FIRST_DECAY_GAIN:  first_decay_gain_reg  <= pwdata;
                    REG_SECOND_DECAY_GAIN: second_decay_gain_reg <= pwdata;
                    REG_RELEASE_GAIN:      release_gain_reg      <= pwdata;
                    REG_PEAK_LEVEL:        peak_level_reg  <= LEVEL_BITS'(pwdata[23:0]);
                    REG_BREAK_LEVEL:       break_level_reg <= LEVEL_BITS'(pwdata[23:0]);
                    default: ;
                endcase
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= produce;
            end
            level_reg <= level_next;
            phase_reg <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_opcode_reg <= opcode;
            s1_sample_reg <= sample_in;
        end
        if (produce)
        begin
            sample_out_reg <= scaled;
            phase_now_reg  <= phase_next;
            voice_done_reg <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign phase_now  = phase_now_reg;
    assign voice_done = voice_done_reg;

    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && voice_done_reg |-> phase_now_reg == PH_SILENT)
        else $error("voice_done without silent phase");

    a_note_on_attack: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && s1_opcode_reg == OP_NOTE_ON |=> phase_reg == PH_ATTACK)
        else $error("note on did not enter attack");

    a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && s1_opcode_reg == OP_SAMPLE |=> out_valid_reg)
        else $error("sample transaction gave no result");

    a_no_result_else: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !(s1_valid_reg && s1_opcode_reg == OP_SAMPLE) |=> !out_valid_reg)
        else $error("result without sample transaction");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with free stage");

endmodule
